// ----- design/barycentric_coordinates_core_macros.svh -----
// ----------------------------------------------------------------------------
// Barycentric core assertion macros
// Concurrent assertion wrappers; they compile to nothing under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef BARYCENTRIC_COORDINATES_CORE_MACROS_SVH
`define BARYCENTRIC_COORDINATES_CORE_MACROS_SVH

`ifndef SYNTHESIS
// checked outside reset only
`define BCC_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("barycentric core assertion failed");
// checked at every edge, reset included
`define BCC_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("barycentric core assertion failed");
`else
`define BCC_ASSERT(lbl, clk, rst_n, prop)
`define BCC_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ----- design/bcc_pkg.sv -----
// ----------------------------------------------------------------------------
// Barycentric core package
// Payload types, internal widths and shared constants.
// ----------------------------------------------------------------------------
package bcc_pkg;

	// coordinate and derived widths
	localparam int COORD_W  = 16;
	localparam int EDGE_W   = COORD_W + 1;
	localparam int PROD_W   = 2 * EDGE_W;
	localparam int DOT_W    = PROD_W + 2;
	localparam int HALF_W   = DOT_W / 2;
	localparam int MUL_W    = 2 * DOT_W;
	localparam int DET_W    = MUL_W + 1;
	localparam int MAG_W    = DET_W;
	localparam int NUM_W    = MAG_W + 18;
	localparam int DEN_W    = MAG_W + 1;
	localparam int REM_W    = MAG_W + 2;
	localparam int SQ_W     = NUM_W + 1;
	localparam int U_W      = SQ_W + 2;
	localparam int CMP_W    = MAG_W + 33;
	localparam int THR_W    = 32;
	localparam int WGT_W    = 32;

	// front-to-back queue
	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

	// weight constants, Q16.16
	localparam logic signed [WGT_W-1:0] WGT_ONE  = 32'sh0001_0000;
	localparam logic signed [WGT_W-1:0] WGT_ZERO = 32'sh0000_0000;
	localparam logic signed [WGT_W-1:0] WGT_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [WGT_W-1:0] WGT_MIN  = 32'sh8000_0000;

	typedef struct packed {
		logic signed [COORD_W-1:0] point_x;
		logic signed [COORD_W-1:0] point_y;
		logic signed [COORD_W-1:0] point_z;
		logic signed [COORD_W-1:0] corner_a_x;
		logic signed [COORD_W-1:0] corner_a_y;
		logic signed [COORD_W-1:0] corner_a_z;
		logic signed [COORD_W-1:0] corner_b_x;
		logic signed [COORD_W-1:0] corner_b_y;
		logic signed [COORD_W-1:0] corner_b_z;
		logic signed [COORD_W-1:0] corner_c_x;
		logic signed [COORD_W-1:0] corner_c_y;
		logic signed [COORD_W-1:0] corner_c_z;
	} query_t;

	typedef struct packed {
		logic signed [WGT_W-1:0] weight_u;
		logic signed [WGT_W-1:0] weight_v;
		logic signed [WGT_W-1:0] weight_w;
		logic                    degenerate;
		logic                    saturated;
	} result_t;

	// classified item handed from front to back
	typedef struct packed {
		logic [MAG_W-1:0] mag_nv;
		logic [MAG_W-1:0] mag_nw;
		logic [MAG_W-1:0] mag_det;
		logic             neg_v;
		logic             neg_w;
		logic             degen;
	} front_res_t;

	// control bits riding alongside the divider
	typedef struct packed {
		logic valid;
		logic degen;
		logic neg_v;
		logic neg_w;
	} side_t;

endpackage

// ----- design/bcc_mul.sv -----
// ----------------------------------------------------------------------------
// Split multiplier
// Signed dot x dot product over two stages: two half products, then the sum.
// ----------------------------------------------------------------------------
module bcc_mul (
	input  logic                              clk,
	input  logic signed [bcc_pkg::DOT_W-1:0]  a,
	input  logic signed [bcc_pkg::DOT_W-1:0]  b,
	output logic signed [bcc_pkg::MUL_W-1:0]  p
);
	import bcc_pkg::*;

	localparam int LO_W = DOT_W + HALF_W + 1;
	localparam int HI_W = 2 * DOT_W - HALF_W;

	logic signed [LO_W-1:0] lo_s1;
	logic signed [HI_W-1:0] hi_s1;
	logic signed [HALF_W:0]        b_lo;
	logic signed [DOT_W-HALF_W-1:0] b_hi;

	assign b_lo = $signed({1'b0, b[HALF_W-1:0]});
	assign b_hi = $signed(b[DOT_W-1:HALF_W]);

	// half products
	always_ff @(posedge clk) begin
		lo_s1 <= LO_W'(a * b_lo);
		hi_s1 <= HI_W'(a * b_hi);
	end

	// recombine
	always_ff @(posedge clk) begin
		p <= (MUL_W'(hi_s1) <<< HALF_W) + MUL_W'(lo_s1);
	end

endmodule

// ----- design/bcc_front.sv -----
// ----------------------------------------------------------------------------
// Barycentric front end
// Edge vectors, dot products, determinant, numerators and degeneracy test.
// ----------------------------------------------------------------------------
module bcc_front #(
	parameter int FRAC_BITS = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [bcc_pkg::THR_W-1:0]    zero_threshold,
	input  logic                         in_valid,
	input  bcc_pkg::query_t              query,
	output logic                         out_valid,
	output bcc_pkg::front_res_t          out_data
);
	import bcc_pkg::*;

	localparam int THR_SH = 4 * FRAC_BITS;

	logic [7:0] v_q;

	logic signed [EDGE_W-1:0] e0_s1 [3];
	logic signed [EDGE_W-1:0] e1_s1 [3];
	logic signed [EDGE_W-1:0] e2_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [5][3];
	logic signed [DOT_W-1:0]  dot_s3 [5];
	logic signed [MUL_W-1:0]  mp_s5 [6];
	logic signed [DET_W-1:0]  det_s6, nv_s6, nw_s6;
	logic [MAG_W-1:0]         mdet_s7, mnv_s7, mnw_s7;
	logic                     negv_s7, negw_s7;
	logic signed [COORD_W-1:0] pc [3], ac [3], bc [3], cc [3];
	logic [CMP_W-1:0]         lhs, rhs;

	assign pc = '{query.point_x, query.point_y, query.point_z};
	assign ac = '{query.corner_a_x, query.corner_a_y, query.corner_a_z};
	assign bc = '{query.corner_b_x, query.corner_b_y, query.corner_b_z};
	assign cc = '{query.corner_c_x, query.corner_c_y, query.corner_c_z};

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else begin
			v_q <= {v_q[6:0], in_valid};
		end
	end
	assign out_valid = v_q[7];

	// s1: edge vectors
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			e0_s1[k] <= EDGE_W'(bc[k]) - EDGE_W'(ac[k]);
			e1_s1[k] <= EDGE_W'(cc[k]) - EDGE_W'(ac[k]);
			e2_s1[k] <= EDGE_W'(pc[k]) - EDGE_W'(ac[k]);
		end
	end

	// s2: component products for d00, d01, d11, d20, d21
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			prod_s2[0][k] <= PROD_W'(e0_s1[k] * e0_s1[k]);
			prod_s2[1][k] <= PROD_W'(e0_s1[k] * e1_s1[k]);
			prod_s2[2][k] <= PROD_W'(e1_s1[k] * e1_s1[k]);
			prod_s2[3][k] <= PROD_W'(e2_s1[k] * e0_s1[k]);
			prod_s2[4][k] <= PROD_W'(e2_s1[k] * e1_s1[k]);
		end
	end

	// s3: dot products
	always_ff @(posedge clk) begin
		for (int j = 0; j < 5; j++) begin
			dot_s3[j] <= DOT_W'(prod_s2[j][0]) + DOT_W'(prod_s2[j][1])
				+ DOT_W'(prod_s2[j][2]);
		end
	end

	// s4-s5: determinant and numerator products
	bcc_mul u_mul_0 (.clk(clk), .a(dot_s3[0]), .b(dot_s3[2]), .p(mp_s5[0]));
	bcc_mul u_mul_1 (.clk(clk), .a(dot_s3[1]), .b(dot_s3[1]), .p(mp_s5[1]));
	bcc_mul u_mul_2 (.clk(clk), .a(dot_s3[2]), .b(dot_s3[3]), .p(mp_s5[2]));
	bcc_mul u_mul_3 (.clk(clk), .a(dot_s3[1]), .b(dot_s3[4]), .p(mp_s5[3]));
	bcc_mul u_mul_4 (.clk(clk), .a(dot_s3[0]), .b(dot_s3[4]), .p(mp_s5[4]));
	bcc_mul u_mul_5 (.clk(clk), .a(dot_s3[1]), .b(dot_s3[3]), .p(mp_s5[5]));

	// s6: det and numerators
	always_ff @(posedge clk) begin
		det_s6 <= DET_W'(mp_s5[0]) - DET_W'(mp_s5[1]);
		nv_s6  <= DET_W'(mp_s5[2]) - DET_W'(mp_s5[3]);
		nw_s6  <= DET_W'(mp_s5[4]) - DET_W'(mp_s5[5]);
	end

	// s7: magnitudes and quotient signs
	always_ff @(posedge clk) begin
		mdet_s7 <= det_s6[DET_W-1] ? MAG_W'(-det_s6) : MAG_W'(det_s6);
		mnv_s7  <= nv_s6[DET_W-1] ? MAG_W'(-nv_s6) : MAG_W'(nv_s6);
		mnw_s7  <= nw_s6[DET_W-1] ? MAG_W'(-nw_s6) : MAG_W'(nw_s6);
		negv_s7 <= nv_s6[DET_W-1] ^ det_s6[DET_W-1];
		negw_s7 <= nw_s6[DET_W-1] ^ det_s6[DET_W-1];
	end

	// s8: degeneracy, |det| * 2^32 <= thr * 2^(4F)
	assign lhs = CMP_W'({mdet_s7, 32'h0});
	assign rhs = CMP_W'(zero_threshold) << THR_SH;

	always_ff @(posedge clk) begin
		out_data.mag_nv  <= mnv_s7;
		out_data.mag_nw  <= mnw_s7;
		out_data.mag_det <= mdet_s7;
		out_data.neg_v   <= negv_s7;
		out_data.neg_w   <= negw_s7;
		out_data.degen   <= (lhs <= rhs);
	end

endmodule

// ----- design/bcc_fifo.sv -----
// ----------------------------------------------------------------------------
// Front-to-back queue
// Short register queue of classified items between front and back.
// ----------------------------------------------------------------------------
module bcc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  bcc_pkg::front_res_t   push_data,
	input  logic                  pop,
	output bcc_pkg::front_res_t   pop_data,
	output logic                  empty
);
	import bcc_pkg::*;

	front_res_t       mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + PTR_W'(1);
			if (pop)  rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			count_q <= count_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	// storage
	always_ff @(posedge clk) begin
		if (push) mem[wr_ptr_q] <= push_data;
	end

	assign pop_data = mem[rd_ptr_q];
	assign empty    = (count_q == '0);

endmodule

// ----- design/bcc_div.sv -----
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage, most significant first; unsigned operands.
// ----------------------------------------------------------------------------
module bcc_div (
	input  logic                        clk,
	input  logic [bcc_pkg::NUM_W-1:0]   num,
	input  logic [bcc_pkg::DEN_W-1:0]   den,
	output logic [bcc_pkg::NUM_W-1:0]   quo
);
	import bcc_pkg::*;

	logic [REM_W-1:0] rem_s [NUM_W];
	logic [NUM_W-1:0] num_s [NUM_W];
	logic [NUM_W-1:0] quo_s [NUM_W];
	logic [DEN_W-1:0] den_s [NUM_W];

	for (genvar i = 0; i < NUM_W; i++) begin : g_stage
		logic [REM_W-1:0] r_in;
		logic [NUM_W-1:0] n_in;
		logic [NUM_W-1:0] q_in;
		logic [DEN_W-1:0] d_in;
		logic [REM_W-1:0] trial;
		logic             ge;

		if (i == 0) begin : g_first
			assign r_in = '0;
			assign n_in = num;
			assign q_in = '0;
			assign d_in = den;
		end else begin : g_next
			assign r_in = rem_s[i-1];
			assign n_in = num_s[i-1];
			assign q_in = quo_s[i-1];
			assign d_in = den_s[i-1];
		end

		// shift in next numerator bit, trial subtract
		assign trial = {r_in[REM_W-2:0], n_in[NUM_W-1]};
		assign ge    = (trial >= REM_W'(d_in));

		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? (trial - REM_W'(d_in)) : trial;
			num_s[i] <= {n_in[NUM_W-2:0], 1'b0};
			quo_s[i] <= {q_in[NUM_W-2:0], ge};
			den_s[i] <= d_in;
		end
	end

	assign quo = quo_s[NUM_W-1];

endmodule

// ----- design/bcc_back.sv -----
// ----------------------------------------------------------------------------
// Barycentric back end
// Rounded Q16.16 quotients for v and w, u = 1 - v - w, saturation.
// ----------------------------------------------------------------------------
module bcc_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	input  bcc_pkg::front_res_t   in_data,
	output logic                  done,
	output bcc_pkg::result_t      result
);
	import bcc_pkg::*;

	logic [NUM_W-1:0] nv_s1, nw_s1;
	logic [DEN_W-1:0] den_s1;
	side_t            side_s1;
	side_t            side_q [NUM_W];
	logic [NUM_W-1:0] qv, qw;
	logic signed [SQ_W-1:0] v_s3, w_s3;
	side_t            side_s3;
	logic signed [U_W-1:0] u_s4, v_s4, w_s4;
	side_t            side_s4;
	logic signed [U_W-1:0] u_max, u_min;
	logic hi_u, lo_u, hi_v, lo_v, hi_w, lo_w;

	// s1: divider operands, (|n| * 2^17 + |det|) / (2 * |det|)
	always_ff @(posedge clk) begin
		nv_s1  <= {in_data.mag_nv, 17'h0} + NUM_W'(in_data.mag_det);
		nw_s1  <= {in_data.mag_nw, 17'h0} + NUM_W'(in_data.mag_det);
		den_s1 <= {in_data.mag_det, 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1 <= '0;
		end else begin
			side_s1 <= '{valid: in_valid, degen: in_data.degen,
				neg_v: in_data.neg_v, neg_w: in_data.neg_w};
		end
	end

	// s2: dividers
	bcc_div u_div_v (.clk(clk), .num(nv_s1), .den(den_s1), .quo(qv));
	bcc_div u_div_w (.clk(clk), .num(nw_s1), .den(den_s1), .quo(qw));

	// control bits matched to the divider depth
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_W; i++) side_q[i] <= '0;
		end else begin
			side_q[0] <= side_s1;
			for (int i = 1; i < NUM_W; i++) side_q[i] <= side_q[i-1];
		end
	end

	// s3: apply signs
	always_ff @(posedge clk) begin
		v_s3 <= side_q[NUM_W-1].neg_v ? -$signed({1'b0, qv}) : $signed({1'b0, qv});
		w_s3 <= side_q[NUM_W-1].neg_w ? -$signed({1'b0, qw}) : $signed({1'b0, qw});
	end

	// s4: u from unsaturated v and w
	always_ff @(posedge clk) begin
		u_s4 <= U_W'(WGT_ONE) - U_W'(v_s3) - U_W'(w_s3);
		v_s4 <= U_W'(v_s3);
		w_s4 <= U_W'(w_s3);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3 <= '0;
			side_s4 <= '0;
		end else begin
			side_s3 <= side_q[NUM_W-1];
			side_s4 <= side_s3;
		end
	end

	// range checks
	assign u_max = U_W'(WGT_MAX);
	assign u_min = U_W'(WGT_MIN);
	assign hi_u  = (u_s4 > u_max);
	assign lo_u  = (u_s4 < u_min);
	assign hi_v  = (v_s4 > u_max);
	assign lo_v  = (v_s4 < u_min);
	assign hi_w  = (w_s4 > u_max);
	assign lo_w  = (w_s4 < u_min);

	// s5: saturate, degenerate override, result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= side_s4.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (side_s4.degen) begin
			result.weight_u   <= WGT_ONE;
			result.weight_v   <= WGT_ZERO;
			result.weight_w   <= WGT_ZERO;
			result.degenerate <= 1'b1;
			result.saturated  <= 1'b0;
		end else begin
			result.weight_u   <= hi_u ? WGT_MAX : (lo_u ? WGT_MIN : u_s4[WGT_W-1:0]);
			result.weight_v   <= hi_v ? WGT_MAX : (lo_v ? WGT_MIN : v_s4[WGT_W-1:0]);
			result.weight_w   <= hi_w ? WGT_MAX : (lo_w ? WGT_MIN : w_s4[WGT_W-1:0]);
			result.degenerate <= 1'b0;
			result.saturated  <= hi_u | lo_u | hi_v | lo_v | hi_w | lo_w;
		end
	end

endmodule

// ----- design/barycentric_coordinates_core.sv -----
// ----------------------------------------------------------------------------
// Barycentric coordinates core
// Q16.16 barycentric weights of a point against a 3D triangle in Q8.8.
// ----------------------------------------------------------------------------
// One query is taken per clock (start high, busy low) and each result
// appears as a one-cycle done pulse with its result; the
// receiver has no way to stall, so results must be captured when done is
// high. Each query passes through the front pipeline (8 stages), the queue hop,
// the bit-per-stage quotient pipeline (91 stages) and the rounding and
// saturation stages. busy tracks free entries in the 16-entry queue that
// sits between front and back; since the back drains one entry per cycle,
// busy stays low under a continuous stream. zero_threshold is loaded through
// cfg_we/cfg_wdata and should only change while no query is in flight.
// ----------------------------------------------------------------------------
`include "barycentric_coordinates_core_macros.svh"

module barycentric_coordinates_core #(
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [bcc_pkg::THR_W-1:0]  cfg_wdata,
	input  logic                       start,
	input  bcc_pkg::query_t            query,
	output logic                       busy,
	output logic                       done,
	output bcc_pkg::result_t           result
);
	import bcc_pkg::*;

	logic [THR_W-1:0] zero_threshold_q;
	logic [CNT_W-1:0] credit_q;
	logic             accept;
	logic             front_valid;
	front_res_t       front_data;
	front_res_t       head;
	logic             q_empty;
	logic             pop;

	// threshold register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zero_threshold_q <= '0;
		end else if (cfg_we) begin
			zero_threshold_q <= cfg_wdata;
		end
	end

	// queue credits: one per item between accept and pop
	assign accept = start & ~busy;
	assign busy   = (credit_q == '0);
	assign pop    = ~q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= CNT_W'(FIFO_DEPTH);
		end else begin
			credit_q <= credit_q - CNT_W'(accept) + CNT_W'(pop);
		end
	end

	bcc_front #(.FRAC_BITS(FRAC_BITS)) u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.zero_threshold (zero_threshold_q),
		.in_valid       (accept),
		.query          (query),
		.out_valid      (front_valid),
		.out_data       (front_data)
	);

	bcc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (front_valid),
		.push_data (front_data),
		.pop       (pop),
		.pop_data  (head),
		.empty     (q_empty)
	);

	bcc_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (pop),
		.in_data  (head),
		.done     (done),
		.result   (result)
	);

	// credits never exceed the queue depth
	`BCC_ASSERT_ALWAYS(a_credit_range, clk, credit_q <= CNT_W'(FIFO_DEPTH))
	// degenerate transfer carries weights (1,0,0) and no saturation
	`BCC_ASSERT(a_degen_result, clk, arst_n, done && result.degenerate |-> result.weight_u == WGT_ONE && result.weight_v == WGT_ZERO && result.weight_w == WGT_ZERO && !result.saturated)
	// a saturated transfer has at least one weight at a range limit
	`BCC_ASSERT(a_sat_limit, clk, arst_n, done && result.saturated |-> result.weight_u == WGT_MAX || result.weight_u == WGT_MIN || result.weight_v == WGT_MAX || result.weight_v == WGT_MIN || result.weight_w == WGT_MAX || result.weight_w == WGT_MIN)

endmodule

// ----- bench/tb_barycentric_coordinates_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Barycentric coordinates core testbench
// Streams triangle queries through the core under several zero thresholds.
// Each accepted query is run through a wide-integer model of the weights,
// and the expected result is queued. Every done pulse is then checked,
// field by field, against the oldest entry in that queue.
// ----------------------------------------------------------------------------
module tb_barycentric_coordinates_core;
	import bcc_pkg::*;

	typedef logic signed [191:0] wide_t;
	typedef enum logic [1:0] {JOB_QUERY, JOB_THRESH, JOB_DRAIN} job_kind_t;
	typedef struct {
		job_kind_t   kind;
		query_t      q;
		logic [31:0] thr;
		int          gap;
	} job_t;

	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT   = 500000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        start = 1'b0;
	query_t      query = '0;
	logic        busy;
	logic        done;
	result_t     result;

	job_t        jobs[$];
	result_t     expected_weights[$];
	logic [31:0] thr_copy = '0;
	int          gap_left = 0;
	int          settle = 0;
	int          errors = 0;
	int          n_sent = 0;
	int          n_checked = 0;
	int          n_degen = 0;
	int          n_sat = 0;
	int          n_thr = 0;
	int          cycles = 0;

	barycentric_coordinates_core DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.query    (query),
		.busy     (busy),
		.done     (done),
		.result   (result)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	// round(n * 2^16 / d), ties away from zero
	function automatic wide_t q16_ratio(wide_t n, wide_t d);
		wide_t an, ad, qt;
		an = (n < 0) ? -n : n;
		ad = (d < 0) ? -d : d;
		qt = ((an <<< 17) + ad) / (ad <<< 1);
		return ((n < 0) != (d < 0)) ? -qt : qt;
	endfunction

	function automatic logic [31:0] clip_weight(wide_t x, ref logic sat);
		if (x > wide_t'(32'sh7FFF_FFFF)) begin
			sat = 1'b1;
			return WGT_MAX;
		end
		if (x < -wide_t'(64'sh8000_0000)) begin
			sat = 1'b1;
			return WGT_MIN;
		end
		return x[31:0];
	endfunction

	// expected weights of one query under a given threshold
	function automatic result_t weigh_point(query_t q, logic [31:0] thr);
		wide_t a[3], e0[3], e1[3], e2[3];
		wide_t d00, d01, d11, d20, d21, det, mag, v, w, u;
		result_t r;
		logic sat;
		a[0] = wide_t'(q.corner_a_x);
		a[1] = wide_t'(q.corner_a_y);
		a[2] = wide_t'(q.corner_a_z);
		e0[0] = wide_t'(q.corner_b_x) - a[0];
		e0[1] = wide_t'(q.corner_b_y) - a[1];
		e0[2] = wide_t'(q.corner_b_z) - a[2];
		e1[0] = wide_t'(q.corner_c_x) - a[0];
		e1[1] = wide_t'(q.corner_c_y) - a[1];
		e1[2] = wide_t'(q.corner_c_z) - a[2];
		e2[0] = wide_t'(q.point_x) - a[0];
		e2[1] = wide_t'(q.point_y) - a[1];
		e2[2] = wide_t'(q.point_z) - a[2];
		d00 = e0[0]*e0[0] + e0[1]*e0[1] + e0[2]*e0[2];
		d01 = e0[0]*e1[0] + e0[1]*e1[1] + e0[2]*e1[2];
		d11 = e1[0]*e1[0] + e1[1]*e1[1] + e1[2]*e1[2];
		d20 = e2[0]*e0[0] + e2[1]*e0[1] + e2[2]*e0[2];
		d21 = e2[0]*e1[0] + e2[1]*e1[1] + e2[2]*e1[2];
		det = d00*d11 - d01*d01;
		mag = (det < 0) ? -det : det;
		sat = 1'b0;
		// det and threshold share the 2^-32 scale at eight fraction bits
		if (mag <= wide_t'({1'b0, thr})) begin
			r.weight_u   = WGT_ONE;
			r.weight_v   = WGT_ZERO;
			r.weight_w   = WGT_ZERO;
			r.degenerate = 1'b1;
			r.saturated  = 1'b0;
			return r;
		end
		v = q16_ratio(d11*d20 - d01*d21, det);
		w = q16_ratio(d00*d21 - d01*d20, det);
		u = wide_t'(32'sh0001_0000) - v - w;
		r.weight_u   = clip_weight(u, sat);
		r.weight_v   = clip_weight(v, sat);
		r.weight_w   = clip_weight(w, sat);
		r.degenerate = 1'b0;
		r.saturated  = sat;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		if (errors <= 30)
			$display("MISMATCH %s at result %0d: got %h expected %h",
				what, n_checked, got, want);
	endtask

	// mostly back-to-back, some short gaps, rare long ones
	function automatic int pick_gap(bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 88) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 20);
		return $urandom_range(50, 200);
	endfunction

	function automatic query_t mk_query(int px, int py, int pz, int ax, int ay,
			int az, int bx, int by, int bz, int cx, int cy, int cz);
		query_t q;
		q.point_x = px[15:0];     q.point_y = py[15:0];     q.point_z = pz[15:0];
		q.corner_a_x = ax[15:0];  q.corner_a_y = ay[15:0];  q.corner_a_z = az[15:0];
		q.corner_b_x = bx[15:0];  q.corner_b_y = by[15:0];  q.corner_b_z = bz[15:0];
		q.corner_c_x = cx[15:0];  q.corner_c_y = cy[15:0];  q.corner_c_z = cz[15:0];
		return q;
	endfunction

	function automatic int rnd_span(int span);
		return int'($urandom_range(0, 2 * span)) - span;
	endfunction

	// random query; shapes chosen to hit normal, degenerate and clipped cases
	function automatic query_t rand_query();
		query_t q;
		int sel, ax, ay, az, dx, dy, dz, k, s;
		sel = $urandom_range(0, 99);
		if (sel < 25) begin
			q = query_t'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
		end else if (sel < 65) begin
			s = (sel < 45) ? 512 : 4096;
			ax = rnd_span(8000); ay = rnd_span(8000); az = rnd_span(8000);
			q = mk_query(ax + rnd_span(2*s), ay + rnd_span(2*s), az + rnd_span(2*s),
				ax, ay, az,
				ax + rnd_span(s), ay + rnd_span(s), az + rnd_span(s),
				ax + rnd_span(s), ay + rnd_span(s), az + rnd_span(s));
		end else if (sel < 82) begin
			// collinear corners, sometimes nudged off the line
			ax = rnd_span(4000); ay = rnd_span(4000); az = rnd_span(4000);
			dx = rnd_span(300); dy = rnd_span(300); dz = rnd_span(300);
			k = rnd_span(8);
			q = mk_query(rnd_span(30000), rnd_span(30000), rnd_span(30000),
				ax, ay, az, ax + dx, ay + dy, az + dz,
				ax + k*dx + rnd_span(1), ay + k*dy, az + k*dz + rnd_span(1));
		end else begin
			// tiny triangle, far point
			ax = rnd_span(30000); ay = rnd_span(30000); az = rnd_span(30000);
			q = mk_query(rnd_span(32767), rnd_span(32767), rnd_span(32767),
				ax, ay, az,
				ax + rnd_span(3), ay + rnd_span(3), az + rnd_span(3),
				ax + rnd_span(3), ay + rnd_span(3), az + rnd_span(3));
		end
		return q;
	endfunction

	function automatic void add_query(query_t q, bit steady);
		job_t j;
		j.kind = JOB_QUERY;
		j.q    = q;
		j.thr  = '0;
		j.gap  = pick_gap(steady);
		jobs.push_back(j);
	endfunction

	function automatic void add_job(job_kind_t kind, logic [31:0] thr);
		job_t j;
		j.kind = kind;
		j.q    = '0;
		j.thr  = thr;
		j.gap  = 0;
		jobs.push_back(j);
	endfunction

	// driver: one transfer per accepted start, threshold writes only when idle
	always @(posedge clk) begin
		job_t j;
		if (arst_n) begin
			if (start && !busy) begin
				expected_weights.push_back(weigh_point(query, thr_copy));
				n_sent++;
			end
			settle = (expected_weights.size() == 0 && !start) ? settle + 1 : 0;
			if (start && busy) begin
				cfg_we <= 1'b0;
			end else if (gap_left > 0) begin
				gap_left--;
				start  <= 1'b0;
				cfg_we <= 1'b0;
			end else if (jobs.size() == 0) begin
				start  <= 1'b0;
				cfg_we <= 1'b0;
			end else begin
				j = jobs[0];
				case (j.kind)
					JOB_QUERY: begin
						start    <= 1'b1;
						query    <= j.q;
						cfg_we   <= 1'b0;
						gap_left = j.gap;
						void'(jobs.pop_front());
					end
					JOB_THRESH: begin
						start <= 1'b0;
						if (settle > SETTLE_CYCLES) begin
							cfg_we    <= 1'b1;
							cfg_wdata <= j.thr;
							thr_copy  = j.thr;
							n_thr++;
							void'(jobs.pop_front());
						end else begin
							cfg_we <= 1'b0;
						end
					end
					default: begin
						start  <= 1'b0;
						cfg_we <= 1'b0;
						if (expected_weights.size() == 0) void'(jobs.pop_front());
					end
				endcase
			end
		end
	end

	// monitor: every done pulse is one result transfer
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_weights.size() == 0) begin
				report("unexpected result", result.weight_u, '0);
			end else begin
				want = expected_weights.pop_front();
				if (result.weight_u !== want.weight_u)
					report("weight_u", result.weight_u, want.weight_u);
				if (result.weight_v !== want.weight_v)
					report("weight_v", result.weight_v, want.weight_v);
				if (result.weight_w !== want.weight_w)
					report("weight_w", result.weight_w, want.weight_w);
				if (result.degenerate !== want.degenerate)
					report("degenerate", result.degenerate, want.degenerate);
				if (result.saturated !== want.saturated)
					report("saturated", result.saturated, want.saturated);
				n_degen += want.degenerate;
				n_sat   += want.saturated;
			end
			n_checked++;
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	initial begin
		logic [31:0] thr_set[6];
		int p, i;
		thr_set[0] = 32'h0000_0000;
		thr_set[1] = 32'hFFFF_FFFF;
		thr_set[2] = 32'h0000_0001;
		thr_set[3] = $urandom;
		thr_set[4] = $urandom_range(0, 65535);
		thr_set[5] = 32'h0000_0000;

		// directed corners of the space
		add_job(JOB_THRESH, 32'h0);
		add_query('0, 0);
		add_query(mk_query(32767, 32767, 32767, 32767, 32767, 32767,
			32767, 32767, 32767, 32767, 32767, 32767), 0);
		add_query('1, 0);
		add_query(mk_query(-32768, -32768, -32768, -32768, -32768, -32768,
			-32768, -32768, -32768, -32768, -32768, -32768), 0);
		// unit triangle: point on each corner, centroid, outside
		add_query(mk_query(0, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
		add_query(mk_query(256, 0, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
		add_query(mk_query(0, 256, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
		add_query(mk_query(85, 85, 0, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
		add_query(mk_query(-32768, 32767, 500, 0, 0, 0, 256, 0, 0, 0, 256, 0), 0);
		add_query(mk_query(128, 128, 77, 0, 0, 0, 256, 0, 0, 0, 256, 0), 1);
		// full-range triangle
		add_query(mk_query(0, 0, 0, -32768, -32768, -32768,
			32767, -32768, 32767, -32768, 32767, 32767), 0);
		add_query(mk_query(32767, -32768, 32767, 32767, 32767, -32768,
			-32768, 32767, 32767, 32767, -32768, 32767), 0);
		// collinear corners: zero determinant
		add_query(mk_query(9, 9, 9, 0, 0, 0, 10, 20, 30, 20, 40, 60), 0);
		// smallest triangle with far point: clipped weights
		add_query(mk_query(32767, -32768, 32767, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
		add_query(mk_query(-32768, 32767, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0), 0);
		add_query(mk_query(32767, 32767, 0, 0, 0, 0, 1, 0, 0, 1, 1, 1), 0);
		add_job(JOB_DRAIN, 32'h0);

		// random phases, one threshold each, with a drain in the middle
		for (p = 0; p < 6; p++) begin
			add_job(JOB_THRESH, thr_set[p]);
			for (i = 0; i < 305; i++) begin
				add_query(rand_query(), (i % 120) < 30);
				if (i == 150) add_job(JOB_DRAIN, 32'h0);
			end
			add_job(JOB_DRAIN, 32'h0);
		end

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		wait (jobs.size() == 0 && expected_weights.size() == 0 && !start);
		repeat (150) @(posedge clk);

		$display("Checked %0d of %0d queries under %0d thresholds", n_checked,
			n_sent, n_thr);
		$display("Degenerate triangles: %0d, clipped results: %0d", n_degen, n_sat);
		if (errors == 0 && expected_weights.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
